### rtl/dual_psg_tone_noise_synth_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual tone and noise synthesizer
// Concurrent assertion shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DUAL_PSG_TONE_NOISE_SYNTH_MACROS_SVH
`define DUAL_PSG_TONE_NOISE_SYNTH_MACROS_SVH

`define DPSG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define DPSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/dpsg_pkg.sv
// ----------------------------------------------------------------------------
// Dual tone and noise synthesizer package
// Shared constants, command and status types and the volume table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpsg_pkg;

   localparam int NUM_CHIPS_DEF = 2;
   localparam int MAX_TICKS_DEF = 63;

   localparam int STEP_W = 22;
   localparam logic [STEP_W-1:0] STEP_RESET = 22'd65536;
   localparam logic [15:0] NOISE_SEED = 16'h8000;
   localparam int MAX_CHIP_LEVEL = 192;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic start_sample;
      logic write;
      logic tick;
      logic div_start;
      logic div_step;
      logic hold_load;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic last_tick;
      logic div_last;
   } status_type;

   function automatic logic [5:0] vol_lookup(input logic [3:0] atten);
      logic [5:0] v;
      case (atten)
         4'd0: v = 6'd48;
         4'd1: v = 6'd38;
         4'd2: v = 6'd30;
         4'd3: v = 6'd24;
         4'd4: v = 6'd19;
         4'd5: v = 6'd15;
         4'd6: v = 6'd12;
         4'd7: v = 6'd10;
         4'd8: v = 6'd8;
         4'd9: v = 6'd6;
         4'd10: v = 6'd5;
         4'd11: v = 6'd4;
         4'd12: v = 6'd3;
         4'd13: v = 6'd2;
         4'd14: v = 6'd2;
         default: v = 6'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/dpsg_ctrl.sv
// ----------------------------------------------------------------------------
// Dual tone and noise synthesizer controller
// Sequences writes, tick runs, the division and the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dpsg_pkg::cmd_type    cmd,
   input  dpsg_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_TICK, ST_ACCUM, ST_DIVINIT, ST_DIV, ST_HOLD, ST_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.start_sample = req_valid && (req_op == dpsg_pkg::OP_SAMPLE);
            cmd.write = req_valid && (req_op == dpsg_pkg::OP_WRITE);
         end
         ST_TICK: cmd.tick = 1'b1;
         ST_DIVINIT: cmd.div_start = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_HOLD: cmd.hold_load = 1'b1;
         ST_OUT: cmd.load_out = slot_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_OUT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_op == dpsg_pkg::OP_SAMPLE)) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: state_ff <= status.n_zero ? ST_OUT : ST_TICK;
            ST_TICK: begin
               if (status.last_tick) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM: state_ff <= ST_DIVINIT;
            ST_DIVINIT: state_ff <= ST_DIV;
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: state_ff <= ST_OUT;
            ST_OUT: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### rtl/dpsg_datapath.sv
// ----------------------------------------------------------------------------
// Dual tone and noise synthesizer datapath
// Voice state, tick logic, level accumulator, divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpsg_datapath #(
   parameter int NUM_CHIPS = dpsg_pkg::NUM_CHIPS_DEF,
   parameter int MAX_TICKS = dpsg_pkg::MAX_TICKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [dpsg_pkg::STEP_W-1:0] csr_wr_data,
   input  logic                        req_chip_sel,
   input  logic [7:0]                  req_data_byte,
   input  logic [7:0]                  req_mix_in,
   output logic [7:0]                  rsp_sample_out,
   input  dpsg_pkg::cmd_type           cmd,
   output dpsg_pkg::status_type        status
);

   localparam int VOICES = NUM_CHIPS * 4;
   localparam int TICK_W = $clog2(MAX_TICKS + 1);
   localparam int LVL_W = $clog2(NUM_CHIPS * dpsg_pkg::MAX_CHIP_LEVEL + 1);
   localparam int SUM_W = $clog2(MAX_TICKS * NUM_CHIPS * dpsg_pkg::MAX_CHIP_LEVEL + 1);
   localparam int DCNT_W = $clog2(SUM_W + 1);

   logic [9:0]  period_ff [VOICES];
   logic [9:0]  period_in [VOICES];
   logic [3:0]  atten_ff [VOICES];
   logic [3:0]  atten_in [VOICES];
   logic [10:0] count_ff [VOICES];
   logic [10:0] count_in [VOICES];
   logic        level_ff [VOICES];
   logic        level_in [VOICES];
   logic [2:0]  latched_ff [NUM_CHIPS];
   logic [2:0]  latched_in [NUM_CHIPS];
   logic [15:0] shift_ff [NUM_CHIPS];
   logic [15:0] shift_in [NUM_CHIPS];
   logic        nbit_ff [NUM_CHIPS];
   logic        nbit_in [NUM_CHIPS];

   logic [dpsg_pkg::STEP_W-1:0] step_ff;
   logic [15:0]       phase_ff;
   logic [7:0]        held_ff;
   logic [7:0]        mix_ff;
   logic [7:0]        out_ff;
   logic [TICK_W-1:0] n_ff;
   logic [TICK_W-1:0] cnt_ff;
   logic              tick_done_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [TICK_W-1:0] rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   logic [dpsg_pkg::STEP_W:0] acc;
   logic [7:0]        n_raw;
   logic [7:0]        n_sat;
   logic [LVL_W-1:0]  level_sum;
   logic [TICK_W:0]   rem_sh;
   logic              rem_ge;
   logic [8:0]        mix_sum;

   assign acc = {1'b0, step_ff} + {{(dpsg_pkg::STEP_W - 15){1'b0}}, phase_ff};
   assign n_raw = {1'b0, acc[dpsg_pkg::STEP_W:16]};
   assign n_sat = (n_raw > 8'(MAX_TICKS)) ? 8'(MAX_TICKS) : n_raw;

   always_comb begin
      level_sum = '0;
      for (int c = 0; c < NUM_CHIPS; c++) begin
         for (int v = 0; v < 3; v++) begin
            if (level_ff[c*4+v]) begin
               level_sum = level_sum + LVL_W'(dpsg_pkg::vol_lookup(atten_ff[c*4+v]));
            end
         end
         if (nbit_ff[c]) begin
            level_sum = level_sum + LVL_W'(dpsg_pkg::vol_lookup(atten_ff[c*4+3]));
         end
      end
   end

   always_comb begin
      logic [2:0]  rsel;
      logic [9:0]  p;
      logic [10:0] np;
      logic [15:0] s;
      for (int i = 0; i < VOICES; i++) begin
         period_in[i] = period_ff[i];
         atten_in[i] = atten_ff[i];
         count_in[i] = count_ff[i];
         level_in[i] = level_ff[i];
      end
      for (int c = 0; c < NUM_CHIPS; c++) begin
         latched_in[c] = latched_ff[c];
         shift_in[c] = shift_ff[c];
         nbit_in[c] = nbit_ff[c];
      end
      rsel = '0;
      p = '0;
      np = '0;
      s = '0;
      if (cmd.write) begin
         for (int c = 0; c < NUM_CHIPS; c++) begin
            if (c == int'(req_chip_sel)) begin
               rsel = req_data_byte[7] ? req_data_byte[6:4] : latched_ff[c];
               latched_in[c] = rsel;
               for (int v = 0; v < 4; v++) begin
                  if (rsel[2:1] == 2'(v)) begin
                     if (rsel[0]) begin
                        atten_in[c*4+v] = req_data_byte[3:0];
                     end else if (v < 3) begin
                        if (req_data_byte[7]) begin
                           period_in[c*4+v] = {period_ff[c*4+v][9:4], req_data_byte[3:0]};
                        end else begin
                           period_in[c*4+v] = {req_data_byte[5:0], period_ff[c*4+v][3:0]};
                        end
                     end else begin
                        period_in[c*4+v] = {7'd0, req_data_byte[2:0]};
                        shift_in[c] = dpsg_pkg::NOISE_SEED;
                        nbit_in[c] = 1'b0;
                     end
                  end
               end
            end
         end
      end
      if (cmd.tick) begin
         for (int c = 0; c < NUM_CHIPS; c++) begin
            for (int v = 0; v < 3; v++) begin
               p = period_ff[c*4+v];
               if (p <= 10'd1) begin
                  level_in[c*4+v] = 1'b1;
                  count_in[c*4+v] = '0;
               end else if (count_ff[c*4+v] <= 11'd1) begin
                  count_in[c*4+v] = count_ff[c*4+v] + {1'b0, p} - 11'd1;
                  level_in[c*4+v] = !level_ff[c*4+v];
               end else begin
                  count_in[c*4+v] = count_ff[c*4+v] - 11'd1;
               end
            end
            case (period_ff[c*4+3][1:0])
               2'd0: np = 11'd16;
               2'd1: np = 11'd32;
               2'd2: np = 11'd64;
               default: np = (period_ff[c*4+2] == 10'd0) ? 11'd1 : {1'b0, period_ff[c*4+2]};
            endcase
            if (count_ff[c*4+3] <= 11'd1) begin
               count_in[c*4+3] = count_ff[c*4+3] + np - 11'd1;
               level_in[c*4+3] = !level_ff[c*4+3];
               if (level_ff[c*4+3]) begin
                  s = shift_ff[c];
                  shift_in[c] = {period_ff[c*4+3][2] ? (s[0] ^ s[3]) : s[0], s[15:1]};
                  nbit_in[c] = s[1];
               end
            end else begin
               count_in[c*4+3] = count_ff[c*4+3] - 11'd1;
            end
         end
      end
   end

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge = rem_sh >= {1'b0, n_ff};
   assign mix_sum = {1'b0, mix_ff} + {1'b0, held_ff};

   assign status.n_zero = (n_ff == '0);
   assign status.last_tick = (cnt_ff == TICK_W'(1));
   assign status.div_last = (dcnt_ff == DCNT_W'(1));
   assign rsp_sample_out = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            period_ff[i] <= '0;
            atten_ff[i] <= 4'hF;
            count_ff[i] <= '0;
            level_ff[i] <= 1'b1;
         end
         for (int c = 0; c < NUM_CHIPS; c++) begin
            latched_ff[c] <= '0;
            shift_ff[c] <= dpsg_pkg::NOISE_SEED;
            nbit_ff[c] <= 1'b0;
         end
         step_ff <= dpsg_pkg::STEP_RESET;
         phase_ff <= '0;
         held_ff <= '0;
         tick_done_ff <= 1'b0;
      end else begin
         for (int i = 0; i < VOICES; i++) begin
            period_ff[i] <= period_in[i];
            atten_ff[i] <= atten_in[i];
            count_ff[i] <= count_in[i];
            level_ff[i] <= level_in[i];
         end
         for (int c = 0; c < NUM_CHIPS; c++) begin
            latched_ff[c] <= latched_in[c];
            shift_ff[c] <= shift_in[c];
            nbit_ff[c] <= nbit_in[c];
         end
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         if (cmd.start_sample) begin
            phase_ff <= acc[15:0];
         end
         if (cmd.hold_load) begin
            held_ff <= (quo_ff > SUM_W'(255)) ? 8'd255 : quo_ff[7:0];
         end
         tick_done_ff <= cmd.tick;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_sample) begin
         n_ff <= n_sat[TICK_W-1:0];
         cnt_ff <= n_sat[TICK_W-1:0];
         mix_ff <= req_mix_in;
         sum_ff <= '0;
      end else begin
         if (cmd.tick) begin
            cnt_ff <= cnt_ff - TICK_W'(1);
         end
         if (tick_done_ff) begin
            sum_ff <= sum_ff + SUM_W'(level_sum);
         end
      end
      if (cmd.div_start) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
         dcnt_ff <= DCNT_W'(SUM_W);
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? TICK_W'(rem_sh - {1'b0, n_ff}) : rem_sh[TICK_W-1:0];
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
      if (cmd.load_out) begin
         out_ff <= mix_sum[8] ? 8'd255 : mix_sum[7:0];
      end
   end

endmodule

### rtl/dual_psg_tone_noise_synth.sv
// ----------------------------------------------------------------------------
// Dual tone and noise synthesizer
// Two sound generators with tone and noise voices, mixed into an audio byte.
// ----------------------------------------------------------------------------
// The req channel takes one word per item: op selects a register write byte
// to the chip given by chip_sel, or a sample request that carries mix_in.
// A write word is taken in the idle state and returns nothing. A sample word
// returns one rsp word, sample_out, after n chip ticks for that sample (at
// most MAX_TICKS, one per cycle in the tick loop) and a shift-subtract
// division of the tick sum by n, one quotient bit per cycle for SUM_W bits,
// SUM_W being the width of the tick sum (15 with the default parameters).
// With no ticks the held level is reused and the word goes straight to output.
// The step is written on csr_wr_en; write it only while idle (not enforced).
// Reset restores all voices to silent, the noise registers to their seed and
// the step to one tick per sample. When the receiver stalls, the finished
// word waits in the output register; writes are still taken, and a new
// sample request is computed but waits before its result is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dual_psg_tone_noise_synth_macros.svh"

module dual_psg_tone_noise_synth #(
   parameter int NUM_CHIPS = dpsg_pkg::NUM_CHIPS_DEF,
   parameter int MAX_TICKS = dpsg_pkg::MAX_TICKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [dpsg_pkg::STEP_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic                        req_chip_sel,
   input  logic [7:0]                  req_data_byte,
   input  logic [7:0]                  req_mix_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_sample_out
);

   dpsg_pkg::cmd_type    cmd;
   dpsg_pkg::status_type status;

   dpsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dpsg_datapath #(
      .NUM_CHIPS (NUM_CHIPS),
      .MAX_TICKS (MAX_TICKS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_chip_sel   (req_chip_sel),
      .req_data_byte  (req_data_byte),
      .req_mix_in     (req_mix_in),
      .rsp_sample_out (rsp_sample_out),
      .cmd            (cmd),
      .status         (status)
   );

   `DPSG_ASSERT_NEXT(a_sample_busy, clock, reset,
      req_valid && req_ready && (req_op == dpsg_pkg::OP_SAMPLE), !req_ready)
   `DPSG_ASSERT_NEXT(a_write_one_cycle, clock, reset,
      req_valid && req_ready && (req_op == dpsg_pkg::OP_WRITE), req_ready)
   `DPSG_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule
